### hw/rtl/mime_header_line_tokenizer_defines.svh
// Assertion macros used by the back of the header tokenizer RTL.
`ifndef MIME_HEADER_LINE_TOKENIZER_DEFINES_SVH
`define MIME_HEADER_LINE_TOKENIZER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MHLT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mhlt assertion failed");

// Check that a condition in one cycle leads to another in the next cycle.
`define MHLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhlt assertion failed");

`endif

### hw/rtl/mhlt_pkg.sv
// Types, constants and codes of the header line tokenizer.
package mhlt_pkg;

  localparam int LEN_WIDTH_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int FIELD_WIDTH     = 16;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;

  // Byte class handed from the front to the back.
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LF,
    CLS_CR,
    CLS_COLON,
    CLS_BLANK,
    CLS_EOS
  } cls_t;

  typedef enum logic [2:0] {
    MODE_NAME,
    MODE_GAP,
    MODE_VALUE,
    MODE_NEWLINE,
    MODE_CONT,
    MODE_DONE,
    MODE_ERR_NAME,
    MODE_ERR_OVF
  } mode_t;

  typedef struct packed {
    logic                   header_valid;
    logic [FIELD_WIDTH-1:0] name_length;
    logic [FIELD_WIDTH-1:0] gap_length;
    logic [FIELD_WIDTH-1:0] value_length;
    logic                   block_done;
    logic [1:0]             error_code;
  } res_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/mhlt_ifs.sv
// Valid/ready channel interfaces for input bytes and header records.
interface mhlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface mhlt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            header_valid;
  logic [mhlt_pkg::FIELD_WIDTH-1:0] name_length;
  logic [mhlt_pkg::FIELD_WIDTH-1:0] gap_length;
  logic [mhlt_pkg::FIELD_WIDTH-1:0] value_length;
  logic                            block_done;
  logic [1:0]                      error_code;

  modport source (output valid, output header_valid, output name_length, output gap_length,
                  output value_length, output block_done, output error_code, input ready);
  modport sink (input valid, input header_valid, input name_length, input gap_length,
                input value_length, input block_done, input error_code, output ready);
endinterface

### hw/rtl/mhlt_front.sv
// Front: accept input words and classify each byte for the back.
module mhlt_front (
  mhlt_in_if.sink         rx,
  input  mhlt_pkg::q_stat_t q_stat,
  output logic            push,
  output mhlt_pkg::cls_t  push_cls
);

  assign rx.ready = !q_stat.full;
  assign push     = rx.valid && !q_stat.full;

  always_comb begin
    priority if (rx.end_of_stream) begin
      push_cls = mhlt_pkg::CLS_EOS;
    end else if (rx.data_byte == mhlt_pkg::CH_LF) begin
      push_cls = mhlt_pkg::CLS_LF;
    end else if (rx.data_byte == mhlt_pkg::CH_CR) begin
      push_cls = mhlt_pkg::CLS_CR;
    end else if (rx.data_byte == mhlt_pkg::CH_COLON) begin
      push_cls = mhlt_pkg::CLS_COLON;
    end else if (rx.data_byte == mhlt_pkg::CH_SP || rx.data_byte == mhlt_pkg::CH_TAB) begin
      push_cls = mhlt_pkg::CLS_BLANK;
    end else begin
      push_cls = mhlt_pkg::CLS_OTHER;
    end
  end

endmodule

### hw/rtl/mhlt_queue.sv
// Short class queue between the front and the back.
module mhlt_queue #(
  parameter int DEPTH = mhlt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mhlt_pkg::cls_t    push_cls,
  input  logic              pop,
  output mhlt_pkg::cls_t    head_cls,
  output mhlt_pkg::q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  mhlt_pkg::cls_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;

  assign q_stat.full  = (fill == FULL);
  assign q_stat.empty = (fill == '0);
  assign head_cls     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/mhlt_back.sv
// Back: run the line parser on classified bytes and register each record.
`include "mime_header_line_tokenizer_defines.svh"

module mhlt_back #(
  parameter int LEN_WIDTH = mhlt_pkg::LEN_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mhlt_pkg::cls_t    head_cls,
  input  mhlt_pkg::q_stat_t q_stat,
  output logic              pop,
  mhlt_out_if.source        tx
);

  mhlt_pkg::mode_t mode, mode_next;
  logic [LEN_WIDTH-1:0] name_count, name_count_next;
  logic [LEN_WIDTH-1:0] gap_count, gap_count_next;
  logic [LEN_WIDTH-1:0] value_count, value_count_next;
  logic                 cr_before_lf, cr_before_lf_next;
  logic                 emit;
  mhlt_pkg::res_t       res;
  logic                 out_valid;
  mhlt_pkg::res_t       out_res;

  // Advance one byte whenever the queue is not empty and the output register is free or being drained.
  assign pop = !q_stat.empty && (!out_valid || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= mhlt_pkg::MODE_NAME;
      name_count   <= '0;
      gap_count    <= '0;
      value_count  <= '0;
      cr_before_lf <= 1'b0;
    end else begin
      mode         <= mode_next;
      name_count   <= name_count_next;
      gap_count    <= gap_count_next;
      value_count  <= value_count_next;
      cr_before_lf <= cr_before_lf_next;
    end
  end

  always_comb begin
    mhlt_pkg::mode_t      cur;
    logic [LEN_WIDTH-1:0] nc, gc, vc, rn, rg, rv;
    logic                 cr, ovf, err_name, blk_end, have_rec, fold;

    cur      = mode;
    nc       = name_count;
    gc       = gap_count;
    vc       = value_count;
    cr       = cr_before_lf;
    rn       = '0;
    rg       = '0;
    rv       = '0;
    ovf      = 1'b0;
    err_name = 1'b0;
    blk_end  = 1'b0;
    have_rec = 1'b0;
    fold     = 1'b0;

    mode_next         = mode;
    name_count_next   = name_count;
    gap_count_next    = gap_count;
    value_count_next  = value_count;
    cr_before_lf_next = cr_before_lf;
    emit              = 1'b0;
    res               = '0;

    if (pop) begin
      unique case (mode)
        mhlt_pkg::MODE_ERR_NAME: begin
          emit           = 1'b1;
          res.error_code = mhlt_pkg::ERR_EMPTY;
        end
        mhlt_pkg::MODE_ERR_OVF: begin
          emit           = 1'b1;
          res.error_code = mhlt_pkg::ERR_OVF;
        end
        mhlt_pkg::MODE_DONE: begin
        end
        default: begin
          if (head_cls == mhlt_pkg::CLS_EOS) begin
            mode_next         = mhlt_pkg::MODE_DONE;
            name_count_next   = '0;
            gap_count_next    = '0;
            value_count_next  = '0;
            cr_before_lf_next = 1'b0;
            emit              = 1'b1;
            res.block_done    = 1'b1;
          end else begin
            // A line start after a value: fold, close the pending record, or flag an empty name.
            if (mode == mhlt_pkg::MODE_NEWLINE) begin
              if (head_cls == mhlt_pkg::CLS_BLANK) begin
                fold = 1'b1;
                if (&vc) begin
                  ovf = 1'b1;
                end else begin
                  vc  = vc + LEN_WIDTH'(1);
                  cr  = 1'b0;
                  cur = mhlt_pkg::MODE_CONT;
                end
              end else if (nc == '0) begin
                err_name = 1'b1;
              end else begin
                have_rec = 1'b1;
                rn = nc;
                rg = gc;
                rv = vc;
                if (rv != '0) begin
                  rv = rv - LEN_WIDTH'(1);
                end
                if (cr && rv != '0) begin
                  rv = rv - LEN_WIDTH'(1);
                end
                nc  = '0;
                gc  = '0;
                vc  = '0;
                cr  = 1'b0;
                cur = mhlt_pkg::MODE_NAME;
              end
            end

            if (!fold && !err_name) begin
              unique case (cur)
                mhlt_pkg::MODE_NAME: begin
                  if (head_cls == mhlt_pkg::CLS_LF) begin
                    blk_end = 1'b1;
                    cur     = mhlt_pkg::MODE_DONE;
                  end else if (head_cls == mhlt_pkg::CLS_COLON) begin
                    if (&gc) begin
                      ovf = 1'b1;
                    end else begin
                      gc  = gc + LEN_WIDTH'(1);
                      cur = mhlt_pkg::MODE_GAP;
                    end
                  end else if (&nc) begin
                    ovf = 1'b1;
                  end else begin
                    nc = nc + LEN_WIDTH'(1);
                  end
                end
                mhlt_pkg::MODE_GAP: begin
                  if (head_cls == mhlt_pkg::CLS_BLANK) begin
                    if (&gc) begin
                      ovf = 1'b1;
                    end else begin
                      gc = gc + LEN_WIDTH'(1);
                    end
                  end else if (&vc) begin
                    ovf = 1'b1;
                  end else begin
                    vc = vc + LEN_WIDTH'(1);
                    if (head_cls == mhlt_pkg::CLS_LF) begin
                      cr  = 1'b0;
                      cur = mhlt_pkg::MODE_NEWLINE;
                    end else begin
                      cr  = (head_cls == mhlt_pkg::CLS_CR);
                      cur = mhlt_pkg::MODE_VALUE;
                    end
                  end
                end
                mhlt_pkg::MODE_VALUE: begin
                  if (&vc) begin
                    ovf = 1'b1;
                  end else begin
                    vc = vc + LEN_WIDTH'(1);
                    if (head_cls == mhlt_pkg::CLS_LF) begin
                      cur = mhlt_pkg::MODE_NEWLINE;
                    end else begin
                      cr = (head_cls == mhlt_pkg::CLS_CR);
                    end
                  end
                end
                default: begin
                  if (&vc) begin
                    ovf = 1'b1;
                  end else begin
                    vc = vc + LEN_WIDTH'(1);
                    if (head_cls == mhlt_pkg::CLS_BLANK) begin
                      cr = 1'b0;
                    end else if (head_cls == mhlt_pkg::CLS_LF) begin
                      cr  = 1'b0;
                      cur = mhlt_pkg::MODE_NEWLINE;
                    end else begin
                      cr  = (head_cls == mhlt_pkg::CLS_CR);
                      cur = mhlt_pkg::MODE_VALUE;
                    end
                  end
                end
              endcase
            end

            priority if (ovf) begin
              mode_next      = mhlt_pkg::MODE_ERR_OVF;
              emit           = 1'b1;
              res.error_code = mhlt_pkg::ERR_OVF;
            end else if (err_name) begin
              mode_next      = mhlt_pkg::MODE_ERR_NAME;
              emit           = 1'b1;
              res.error_code = mhlt_pkg::ERR_EMPTY;
            end else begin
              mode_next         = cur;
              name_count_next   = blk_end ? '0 : nc;
              gap_count_next    = blk_end ? '0 : gc;
              value_count_next  = blk_end ? '0 : vc;
              cr_before_lf_next = blk_end ? 1'b0 : cr;
              if (blk_end || have_rec) begin
                emit             = 1'b1;
                res.header_valid = have_rec;
                res.name_length  = mhlt_pkg::FIELD_WIDTH'(rn);
                res.gap_length   = mhlt_pkg::FIELD_WIDTH'(rg);
                res.value_length = mhlt_pkg::FIELD_WIDTH'(rv);
                res.block_done   = blk_end;
              end
            end
          end
        end
      endcase
    end
  end

  // Output register: hold a record until taken, reload when a new one appears.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_res <= res;
    end
  end

  assign tx.valid        = out_valid;
  assign tx.header_valid = out_res.header_valid;
  assign tx.name_length  = out_res.name_length;
  assign tx.gap_length   = out_res.gap_length;
  assign tx.value_length = out_res.value_length;
  assign tx.block_done   = out_res.block_done;
  assign tx.error_code   = out_res.error_code;

  `MHLT_ASSERT(a_err_clean, clk, rst,
    !(out_valid && out_res.error_code != mhlt_pkg::ERR_NONE) ||
    (!out_res.header_valid && !out_res.block_done))
  `MHLT_ASSERT(a_plain_zero, clk, rst,
    !(out_valid && !out_res.header_valid) ||
    (out_res.name_length == '0 && out_res.gap_length == '0 && out_res.value_length == '0))
  `MHLT_ASSERT(a_rec_name, clk, rst,
    !(out_valid && out_res.header_valid) || (out_res.name_length != '0))
  `MHLT_ASSERT_NEXT(a_ovf_sticky, clk, rst,
    mode == mhlt_pkg::MODE_ERR_OVF, mode == mhlt_pkg::MODE_ERR_OVF)
  `MHLT_ASSERT_NEXT(a_done_sticky, clk, rst,
    mode == mhlt_pkg::MODE_DONE, mode == mhlt_pkg::MODE_DONE && !(pop && emit))

endmodule

### hw/rtl/mime_header_line_tokenizer.sv
// Throughput: one byte word per cycle while the queue has room, set by the back's parser step.
// Path: an accepted word waits in the class queue; its record is loaded into the output
//   register and taken from there; a stalled output lets the queue fill first.
// Reset (synchronous, rst high) empties the class queue, returns the parser to name mode
//   with all counts zero and clears the output valid flag; no clearing pass follows.
// Top level of the header line tokenizer: front classifier, class queue, parser back.
module mime_header_line_tokenizer #(
  parameter int LEN_WIDTH   = mhlt_pkg::LEN_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mhlt_pkg::QUEUE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  mhlt_in_if.sink  rx,
  mhlt_out_if.source tx
);

  // Classified bytes flow front -> queue -> back; the queue lets the input keep
  // moving while a finished record waits in the output register.
  logic              push;
  logic              pop;
  mhlt_pkg::cls_t    push_cls;
  mhlt_pkg::cls_t    head_cls;
  mhlt_pkg::q_stat_t q_stat;

  // Front: take a word whenever the queue has room and reduce the byte to a class.
  mhlt_front u_front (
    .rx       (rx),
    .q_stat   (q_stat),
    .push     (push),
    .push_cls (push_cls)
  );

  // Queue: hold classes until the back is free to consume them.
  mhlt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cls (push_cls),
    .pop      (pop),
    .head_cls (head_cls),
    .q_stat   (q_stat)
  );

  // Back: count name, gap and value bytes, fold lines, and report records,
  // block end and sticky errors through a registered output word.
  mhlt_back #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head_cls (head_cls),
    .q_stat   (q_stat),
    .pop      (pop),
    .tx       (tx)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the header line tokenizer: byte stream in, header records out.
module tb_top;

  // Clock and reset.
  localparam int RESET_CYCLES = 7;
  // Random part stops once this many words have gone in, directed part included.
  localparam int RANDOM_WORDS = 1120;
  // Watchdog: end the run after this many cycles with no word moving on either side.
  localparam int STALL_LIMIT  = 1000;
  // The class queue holds four words ahead of the output register, so this covers the drain.
  localparam int DRAIN_CYCLES = 16;
  localparam int LEN_W        = mhlt_pkg::LEN_WIDTH_DEF;

  // How a directed row is checked: against the predictor, against "no result",
  // or against the record typed into the row.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_t;

  typedef struct packed {
    logic [7:0]     data_byte;
    logic           end_of_stream;
    chk_t           chk;
    mhlt_pkg::res_t want;
  } row_t;

  // The one event that closes the block in this run; only reset clears it, and reset
  // is applied once, so the seed picks one per run.
  typedef enum int {
    END_BLANK_LINE,
    END_PARTIAL_NAME,
    END_STREAM,
    END_EMPTY_NAME
  } finale_t;

  localparam mhlt_pkg::res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst;

  mhlt_in_if  in_ch ();
  mhlt_out_if out_ch ();

  mime_header_line_tokenizer dut (
    .clk (clk),
    .rst (rst),
    .rx  (in_ch),
    .tx  (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: parse mode, the three field counters and the CR-before-LF flag.
  mhlt_pkg::mode_t  tok_mode;
  logic [LEN_W-1:0] name_cnt;
  logic [LEN_W-1:0] gap_cnt;
  logic [LEN_W-1:0] val_cnt;
  bit               cr_seen;

  // Records still owed by the block, oldest first.
  mhlt_pkg::res_t pending_records[$];
  int unsigned    faults;
  int unsigned    words_sent;
  int unsigned    results_seen;
  int unsigned    records_seen;
  // Calm stretches turn off idling on both sides; drain holds the sink ready at the end.
  bit             calm;
  bit             drain;
  int unsigned    stall_left;

  // Idle length for either side: mostly none or short, a few long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit at_max(input logic [LEN_W-1:0] cnt);
    return &cnt;
  endfunction

  function automatic void clear_counts();
    name_cnt = '0;
    gap_cnt  = '0;
    val_cnt  = '0;
    cr_seen  = 1'b0;
  endfunction

  // Advance the tokenizer state by one word and work out the result it causes, if any.
  task automatic tokenize_byte(input logic [7:0] b, input logic eos,
                               output bit emits, output mhlt_pkg::res_t rec);
    bit               blank;
    bit               have_rec;
    bit               ovf;
    logic [LEN_W-1:0] rn;
    logic [LEN_W-1:0] rg;
    logic [LEN_W-1:0] rv;
    blank    = (b == mhlt_pkg::CH_SP) || (b == mhlt_pkg::CH_TAB);
    have_rec = 1'b0;
    ovf      = 1'b0;
    rn       = '0;
    rg       = '0;
    rv       = '0;
    emits    = 1'b0;
    rec      = NO_RES;
    if (tok_mode == mhlt_pkg::MODE_ERR_NAME || tok_mode == mhlt_pkg::MODE_ERR_OVF) begin
      // Sticky error: repeat the code on every word, end of stream included.
      emits = 1'b1;
      rec.error_code = (tok_mode == mhlt_pkg::MODE_ERR_NAME) ? mhlt_pkg::ERR_EMPTY
                                                             : mhlt_pkg::ERR_OVF;
    end else if (tok_mode == mhlt_pkg::MODE_DONE) begin
      emits = 1'b0;
    end else if (eos) begin
      // Drop whatever header is partial or pending and close the block.
      tok_mode = mhlt_pkg::MODE_DONE;
      clear_counts();
      emits = 1'b1;
      rec.block_done = 1'b1;
    end else begin
      // A non-blank first byte of a line closes the pending header, or flags an empty name.
      if (tok_mode == mhlt_pkg::MODE_NEWLINE && !blank) begin
        if (name_cnt == '0) begin
          tok_mode = mhlt_pkg::MODE_ERR_NAME;
          emits = 1'b1;
          rec.error_code = mhlt_pkg::ERR_EMPTY;
        end else begin
          have_rec = 1'b1;
          rn = name_cnt;
          rg = gap_cnt;
          rv = val_cnt;
          // Strip the final LF, and the CR right before it.
          if (rv >= 1) rv = rv - 1'b1;
          if (cr_seen && rv >= 1) rv = rv - 1'b1;
          clear_counts();
          tok_mode = mhlt_pkg::MODE_NAME;
        end
      end
      if (tok_mode != mhlt_pkg::MODE_ERR_NAME) begin
        case (tok_mode)
          mhlt_pkg::MODE_NEWLINE: begin
            // Only blanks get here: fold the next line into the value.
            ovf = at_max(val_cnt);
            if (!ovf) begin
              val_cnt  = val_cnt + 1'b1;
              cr_seen  = 1'b0;
              tok_mode = mhlt_pkg::MODE_CONT;
            end
          end
          mhlt_pkg::MODE_NAME: begin
            if (b == mhlt_pkg::CH_LF) begin
              tok_mode = mhlt_pkg::MODE_DONE;
              clear_counts();
              emits = 1'b1;
              rec = {have_rec, mhlt_pkg::FIELD_WIDTH'(rn), mhlt_pkg::FIELD_WIDTH'(rg),
                     mhlt_pkg::FIELD_WIDTH'(rv), 1'b1, mhlt_pkg::ERR_NONE};
              have_rec = 1'b0;
            end else if (b == mhlt_pkg::CH_COLON) begin
              ovf = at_max(gap_cnt);
              if (!ovf) begin
                gap_cnt  = gap_cnt + 1'b1;
                tok_mode = mhlt_pkg::MODE_GAP;
              end
            end else begin
              ovf = at_max(name_cnt);
              if (!ovf) name_cnt = name_cnt + 1'b1;
            end
          end
          mhlt_pkg::MODE_GAP: begin
            if (blank) begin
              ovf = at_max(gap_cnt);
              if (!ovf) gap_cnt = gap_cnt + 1'b1;
            end else begin
              ovf = at_max(val_cnt);
              if (!ovf) begin
                val_cnt = val_cnt + 1'b1;
                if (b == mhlt_pkg::CH_LF) begin
                  cr_seen  = 1'b0;
                  tok_mode = mhlt_pkg::MODE_NEWLINE;
                end else begin
                  cr_seen  = (b == mhlt_pkg::CH_CR);
                  tok_mode = mhlt_pkg::MODE_VALUE;
                end
              end
            end
          end
          mhlt_pkg::MODE_VALUE: begin
            ovf = at_max(val_cnt);
            if (!ovf) begin
              val_cnt = val_cnt + 1'b1;
              if (b == mhlt_pkg::CH_LF) tok_mode = mhlt_pkg::MODE_NEWLINE;
              else cr_seen = (b == mhlt_pkg::CH_CR);
            end
          end
          default: begin
            ovf = at_max(val_cnt);
            if (!ovf) begin
              val_cnt = val_cnt + 1'b1;
              if (blank) begin
                cr_seen = 1'b0;
              end else if (b == mhlt_pkg::CH_LF) begin
                cr_seen  = 1'b0;
                tok_mode = mhlt_pkg::MODE_NEWLINE;
              end else begin
                cr_seen  = (b == mhlt_pkg::CH_CR);
                tok_mode = mhlt_pkg::MODE_VALUE;
              end
            end
          end
        endcase
        if (ovf) begin
          // Overflow wins over a record closed by the same word.
          tok_mode = mhlt_pkg::MODE_ERR_OVF;
          emits = 1'b1;
          rec = NO_RES;
          rec.error_code = mhlt_pkg::ERR_OVF;
        end else if (have_rec) begin
          emits = 1'b1;
          rec = {1'b1, mhlt_pkg::FIELD_WIDTH'(rn), mhlt_pkg::FIELD_WIDTH'(rg),
                 mhlt_pkg::FIELD_WIDTH'(rv), 1'b0, mhlt_pkg::ERR_NONE};
        end
      end
    end
  endtask

  // Drive one word, hold it until accepted, then log what the block owes for it.
  // Lower valid only when a gap follows, so valid never gets two updates in one step.
  task automatic send_word(input logic [7:0] b, input logic eos, input chk_t chk,
                           input mhlt_pkg::res_t want);
    int unsigned    gap;
    bit             emits;
    mhlt_pkg::res_t rec;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tokenize_byte(b, eos, emits, rec);
    case (chk)
      CHK_MODEL: if (emits) pending_records.push_back(rec);
      CHK_GIVEN: pending_records.push_back(want);
      default: ;
    endcase
    words_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_word(b, 1'b0, CHK_MODEL, NO_RES);
  endtask

  // Random non-LF byte, mostly printable; optionally keep blanks and colons out.
  function automatic logic [7:0] pick_byte(input bit no_blank, input bit no_colon);
    logic [7:0] b;
    b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(8'h21, 8'h7E));
    while (b == mhlt_pkg::CH_LF ||
           (no_blank && (b == mhlt_pkg::CH_SP || b == mhlt_pkg::CH_TAB)) ||
           (no_colon && b == mhlt_pkg::CH_COLON))
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(0, 1) ? mhlt_pkg::CH_SP : mhlt_pkg::CH_TAB;
  endfunction

  // Value filler heavy on the bytes the parser cares about: stray CRs, blanks, colons.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return mhlt_pkg::CH_CR;
      1: return mhlt_pkg::CH_COLON;
      2: return blank_byte();
      default: return pick_byte(1'b0, 1'b0);
    endcase
  endfunction

  // Close a value or fold line, with a CR before the LF most of the time.
  task automatic end_line();
    if ($urandom_range(0, 3) != 0) put_byte(mhlt_pkg::CH_CR);
    put_byte(mhlt_pkg::CH_LF);
  endtask

  // One well-formed header: name, colon, blanks, value, then maybe some folded lines.
  // Names never start with a blank or a colon here, so the block stays open.
  task automatic send_header_line();
    int unsigned name_len;
    int unsigned val_len;
    bit          noisy;
    noisy    = ($urandom_range(0, 9) == 0);
    name_len = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    put_byte(pick_byte(1'b1, 1'b1));
    repeat (name_len - 1) put_byte(pick_byte(1'b0, 1'b1));
    put_byte(mhlt_pkg::CH_COLON);
    repeat ($urandom_range(0, 3)) put_byte(blank_byte());
    if ($urandom_range(0, 7) != 0) begin
      val_len = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 160)
                                             : $urandom_range(1, 12);
      put_byte(pick_byte(1'b1, 1'b0));
      repeat (val_len - 1) put_byte(noisy ? noise_byte() : pick_byte(1'b0, 1'b0));
      end_line();
    end else begin
      // Empty value: LF straight after the gap.
      put_byte(mhlt_pkg::CH_LF);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        put_byte(blank_byte());
        repeat ($urandom_range(0, 8)) put_byte(noisy ? noise_byte() : pick_byte(1'b0, 1'b0));
        end_line();
      end
    end
  endtask

  // Sink side: stall at random; no new stall starts during calm stretches or the final drain.
  always @(posedge clk) begin : sink_pacing
    int unsigned n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      n = (calm || drain) ? 0 : idle_len();
      out_ch.ready <= (n == 0);
      stall_left   <= (n == 0) ? 0 : n - 1;
    end
  end

  task automatic compare_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, fname, want, got);
    end
  endtask

  // Check every accepted record against the oldest one owed.
  always @(posedge clk) begin : record_check
    mhlt_pkg::res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.header_valid === 1'b1) records_seen++;
      if (pending_records.size() == 0) begin
        faults++;
        $display("%0t ns: no record expected, got hv=%0b n=%0d g=%0d v=%0d bd=%0b err=%0d",
                 $time, out_ch.header_valid, out_ch.name_length, out_ch.gap_length,
                 out_ch.value_length, out_ch.block_done, out_ch.error_code);
      end else begin
        want = pending_records.pop_front();
        compare_field("header_valid", want.header_valid, out_ch.header_valid);
        compare_field("name_length", want.name_length, out_ch.name_length);
        compare_field("gap_length", want.gap_length, out_ch.gap_length);
        compare_field("value_length", want.value_length, out_ch.value_length);
        compare_field("block_done", want.block_done, out_ch.block_done);
        compare_field("error_code", want.error_code, out_ch.error_code);
      end
    end
  end

  // Watchdog: give up after too many cycles with no word moving on either side.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("%0t ns: watchdog, no handshake for %0d cycles, %0d records still owed",
             $time, STALL_LIMIT, pending_records.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    row_t        directed_rows [25];
    finale_t     finale;
    int unsigned directed_words;
    bit          paused;

    faults       = 0;
    words_sent   = 0;
    results_seen = 0;
    records_seen = 0;
    calm         = 1'b0;
    drain        = 1'b0;
    paused       = 1'b0;
    tok_mode     = mhlt_pkg::MODE_NAME;
    clear_counts();

    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_stream <= 1'b0;

    // Directed part. Three headers exercise the byte extremes in a name, a gap of
    // colon plus space plus tab, CR before LF, a fold of blanks only, LF right after
    // the gap, and a CR-led value with a folded CR line. The records come out when
    // the next line starts, and those are typed in.
    directed_rows = '{
      '{8'hFF,              1'b0, CHK_NONE,  NO_RES},
      '{8'h00,              1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_COLON, 1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_SP,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_TAB,   1'b0, CHK_MODEL, NO_RES},
      '{"v",                1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_CR,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_LF,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_SP,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_TAB,   1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_LF,    1'b0, CHK_MODEL, NO_RES},
      '{"X",                1'b0, CHK_GIVEN,
        mhlt_pkg::res_t'{1'b1, 16'd2, 16'd3, 16'd5, 1'b0, mhlt_pkg::ERR_NONE}},
      '{mhlt_pkg::CH_COLON, 1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_LF,    1'b0, CHK_MODEL, NO_RES},
      '{"Y",                1'b0, CHK_GIVEN,
        mhlt_pkg::res_t'{1'b1, 16'd1, 16'd1, 16'd0, 1'b0, mhlt_pkg::ERR_NONE}},
      '{mhlt_pkg::CH_COLON, 1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_CR,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_LF,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_TAB,   1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_CR,    1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_LF,    1'b0, CHK_MODEL, NO_RES},
      '{"Z",                1'b0, CHK_GIVEN,
        mhlt_pkg::res_t'{1'b1, 16'd1, 16'd1, 16'd3, 1'b0, mhlt_pkg::ERR_NONE}},
      '{mhlt_pkg::CH_COLON, 1'b0, CHK_MODEL, NO_RES},
      '{"q",                1'b0, CHK_MODEL, NO_RES},
      '{mhlt_pkg::CH_LF,    1'b0, CHK_MODEL, NO_RES}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].data_byte, directed_rows[i].end_of_stream,
                directed_rows[i].chk, directed_rows[i].want);
    directed_words = words_sent;

    // Random part: a long open block of well-formed headers with random content.
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 11) == 0) calm = !calm;
      // Once, halfway: drop valid and hold until every owed record has come out.
      if (!paused && words_sent >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0) @(posedge clk);
      end
      send_header_line();
    end

    // Close the block. A header record is pending at this point.
    calm   = 1'b0;
    finale = finale_t'($urandom_range(0, 3));
    case (finale)
      END_BLANK_LINE: begin
        // Record and end of block in one result.
        put_byte(mhlt_pkg::CH_LF);
      end
      END_PARTIAL_NAME: begin
        put_byte(pick_byte(1'b1, 1'b1));
        repeat ($urandom_range(0, 4)) put_byte(pick_byte(1'b0, 1'b1));
        put_byte(mhlt_pkg::CH_LF);
      end
      END_STREAM: begin
        repeat ($urandom_range(0, 6)) put_byte(pick_byte(1'b0, 1'b0));
        send_word(8'($urandom_range(0, 255)), 1'b1, CHK_MODEL, NO_RES);
      end
      default: begin
        // A line that starts with the colon, closed by the next non-blank byte.
        put_byte(mhlt_pkg::CH_COLON);
        put_byte(pick_byte(1'b1, 1'b0));
        put_byte(mhlt_pkg::CH_LF);
        put_byte(pick_byte(1'b1, 1'b1));
      end
    endcase

    // Trailing words: silence after the end of block, the error code again after an error.
    repeat ($urandom_range(8, 24))
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, CHK_MODEL, NO_RES);
    in_ch.valid <= 1'b0;

    // Drain: hold the sink ready, wait for the owed records, then watch for strays.
    drain = 1'b1;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d words in (%0d directed), %0d results out, %0d header records",
             words_sent, directed_words, results_seen, records_seen);
    $display("run: block closed by %s", finale.name());
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", faults);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
